// ===== rtl/acts_pkg.sv =====
// ----------------------------------------------------------------------------
// acts_pkg
// Shared types, tables and helpers for the AES-CBC ciphertext stealing block
// ----------------------------------------------------------------------------
`default_nettype none

package acts_pkg;

	localparam int BLOCK_BYTES = 16;
	localparam logic [3:0] NR_128 = 4'd10;
	localparam logic [3:0] NR_256 = 4'd14;

	typedef logic [7:0] byte_table_t [256];

	localparam byte_table_t SBOX = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// inverse table built at elaboration from the forward one
	function automatic byte_table_t build_inv();
		byte_table_t t;
		for (int i = 0; i < 256; i++) begin
			t[SBOX[i]] = 8'(i);
		end
		return t;
	endfunction

	localparam byte_table_t INV_SBOX = build_inv();

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	typedef enum logic [2:0] {
		CFG_KEY_WORD_0,
		CFG_KEY_WORD_1,
		CFG_KEY_WORD_2,
		CFG_KEY_WORD_3,
		CFG_KEY_SIZE,
		CFG_DIRECTION,
		CFG_IV_HIGH,
		CFG_IV_LOW
	} cfg_idx_t;

	typedef enum logic [2:0] {
		SRC_BLK,
		SRC_HELD,
		SRC_HELD_CHAIN,
		SRC_X_BLK,
		SRC_STEAL
	} src_t;

	typedef enum logic [1:0] {
		OUT_SINGLE,
		OUT_MID,
		OUT_Y,
		OUT_FINAL
	} out_kind_t;

	typedef struct packed {
		logic      cap;
		logic      store_first;
		logic      ks_start;
		logic      aes_load;
		src_t      src;
		logic      save_x;
		logic      out_wr;
		out_kind_t out_kind;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic have_held;
		logic dec;
		logic ks_busy;
		logic aes_busy;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/acts_if.sv =====
// ----------------------------------------------------------------------------
// acts_if
// Channel interfaces: message blocks in, result blocks out, register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface acts_blk_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_high;
	logic [63:0] block_low;
	logic        last_block;
	logic [4:0]  last_bytes;

	modport source (output valid, block_high, block_low, last_block, last_bytes,
		input ready);
	modport sink (input valid, block_high, block_low, last_block, last_bytes,
		output ready);
endinterface

interface acts_res_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_high;
	logic [63:0] out_low;
	logic [4:0]  out_bytes;
	logic        end_of_message;
	logic [63:0] next_iv_high;
	logic [63:0] next_iv_low;

	modport source (output valid, out_high, out_low, out_bytes, end_of_message,
		next_iv_high, next_iv_low, input ready);
	modport sink (input valid, out_high, out_low, out_bytes, end_of_message,
		next_iv_high, next_iv_low, output ready);
endinterface

interface acts_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/acts_keyexp.sv =====
// ----------------------------------------------------------------------------
// acts_keyexp
// Key schedule: one 128-bit round key per cycle into a round key register file
// ----------------------------------------------------------------------------
`default_nettype none

module acts_keyexp (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic         key256,
	input  wire logic [255:0] key,
	input  wire logic [3:0]   ridx,
	output logic [127:0]      rk,
	output logic              busy
);

	logic [127:0] rk_q [15];
	logic [127:0] ka_q, kb_q, base, nxt;
	logic [7:0]   rc_q;
	logic [3:0]   idx_q, nr;
	logic         busy_q, rot;
	logic [31:0]  w, t;

	assign nr   = key256 ? acts_pkg::NR_256 : acts_pkg::NR_128;
	assign busy = busy_q;
	assign rk   = rk_q[ridx];

	always_comb begin
		rot  = !key256 || !idx_q[0];
		base = key256 ? ka_q : kb_q;
		w    = kb_q[31:0];
		if (rot) begin
			w = {w[23:0], w[31:24]};
		end
		t = {acts_pkg::SBOX[w[31:24]], acts_pkg::SBOX[w[23:16]],
			acts_pkg::SBOX[w[15:8]], acts_pkg::SBOX[w[7:0]]};
		if (rot) begin
			t[31:24] = t[31:24] ^ rc_q;
		end
		nxt[127:96] = base[127:96] ^ t;
		nxt[95:64]  = base[95:64] ^ nxt[127:96];
		nxt[63:32]  = base[63:32] ^ nxt[95:64];
		nxt[31:0]   = base[31:0] ^ nxt[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			rc_q   <= 8'h01;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			rc_q   <= 8'h01;
			ka_q   <= key[255:128];
			kb_q   <= key256 ? key[127:0] : key[255:128];
		end else if (busy_q) begin
			idx_q <= idx_q + 4'd1;
			if (idx_q == nr) begin
				busy_q <= 1'b0;
			end
			if (idx_q == 4'd0) begin
				rk_q[idx_q] <= ka_q;
			end else if (key256 && idx_q == 4'd1) begin
				rk_q[idx_q] <= kb_q;
			end else begin
				rk_q[idx_q] <= nxt;
				ka_q        <= kb_q;
				kb_q        <= nxt;
				if (rot) begin
					rc_q <= acts_pkg::xtime(rc_q);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/acts_datapath.sv =====
// ----------------------------------------------------------------------------
// acts_datapath
// Registers, AES round unit, chaining and stealing logic, output register
// ----------------------------------------------------------------------------
`default_nettype none

module acts_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire acts_pkg::cmd_t cmd,
	output acts_pkg::sts_t      sts,
	input  wire logic [63:0]    block_high,
	input  wire logic [63:0]    block_low,
	input  wire logic           last_block,
	input  wire logic [4:0]     last_bytes,
	input  wire logic           cfg_wr,
	input  wire logic [2:0]     cfg_index,
	input  wire logic [63:0]    cfg_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [127:0]        out_data,
	output logic [4:0]          out_bytes,
	output logic                out_eom,
	output logic [127:0]        out_niv
);

	logic [63:0]  key_q [4];
	logic         ks_cfg_q, dir_cfg_q;
	logic [127:0] iv_cfg_q;

	logic [127:0] raw_q, blk_q, ivc_q, held_q, chain_q, x_q, st_q;
	logic [4:0]   nb_q, nb_in;
	logic         last_q, dec_q, ks_q, have_q;
	logic [3:0]   cnt_q, nr, k, ridx;
	logic         busy_q, out_valid_q, out_free;
	logic [127:0] rk, padded, src_val, steal, round_out;
	logic [127:0] blk_in;
	logic         ks_busy;

	function automatic logic [127:0] enc_round(input logic [127:0] s,
		input logic [127:0] key, input logic fin);
		logic [7:0]   t [16];
		logic [7:0]   a0, a1, a2, a3;
		logic [127:0] r;
		for (int c = 0; c < 4; c++) begin
			for (int rr = 0; rr < 4; rr++) begin
				t[rr + 4 * c] = acts_pkg::SBOX[s[127 - 8 * (rr + 4 * ((c + rr) & 3)) -: 8]];
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = t[4 * c];
			a1 = t[4 * c + 1];
			a2 = t[4 * c + 2];
			a3 = t[4 * c + 3];
			if (fin) begin
				r[127 - 32 * c -: 32] = {a0, a1, a2, a3};
			end else begin
				r[127 - 32 * c -: 8] = acts_pkg::xtime(a0) ^ acts_pkg::xtime(a1) ^ a1
					^ a2 ^ a3;
				r[119 - 32 * c -: 8] = a0 ^ acts_pkg::xtime(a1) ^ acts_pkg::xtime(a2)
					^ a2 ^ a3;
				r[111 - 32 * c -: 8] = a0 ^ a1 ^ acts_pkg::xtime(a2)
					^ acts_pkg::xtime(a3) ^ a3;
				r[103 - 32 * c -: 8] = acts_pkg::xtime(a0) ^ a0 ^ a1 ^ a2
					^ acts_pkg::xtime(a3);
			end
		end
		return r ^ key;
	endfunction

	function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] m);
		logic [7:0] x2, x4, x8, r;
		x2 = acts_pkg::xtime(a);
		x4 = acts_pkg::xtime(x2);
		x8 = acts_pkg::xtime(x4);
		r  = (m[0] ? a : 8'h00) ^ (m[1] ? x2 : 8'h00) ^ (m[2] ? x4 : 8'h00)
			^ (m[3] ? x8 : 8'h00);
		return r;
	endfunction

	function automatic logic [127:0] dec_round(input logic [127:0] s,
		input logic [127:0] key, input logic fin);
		logic [127:0] t, r;
		logic [7:0]   a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			for (int rr = 0; rr < 4; rr++) begin
				t[127 - 8 * (rr + 4 * ((c + rr) & 3)) -: 8] =
					acts_pkg::INV_SBOX[s[127 - 8 * (rr + 4 * c) -: 8]];
			end
		end
		t = t ^ key;
		r = t;
		if (!fin) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[127 - 32 * c -: 8];
				a1 = t[119 - 32 * c -: 8];
				a2 = t[111 - 32 * c -: 8];
				a3 = t[103 - 32 * c -: 8];
				r[127 - 32 * c -: 8] = gm(a0, 4'd14) ^ gm(a1, 4'd11) ^ gm(a2, 4'd13)
					^ gm(a3, 4'd9);
				r[119 - 32 * c -: 8] = gm(a0, 4'd9) ^ gm(a1, 4'd14) ^ gm(a2, 4'd11)
					^ gm(a3, 4'd13);
				r[111 - 32 * c -: 8] = gm(a0, 4'd13) ^ gm(a1, 4'd9) ^ gm(a2, 4'd14)
					^ gm(a3, 4'd11);
				r[103 - 32 * c -: 8] = gm(a0, 4'd11) ^ gm(a1, 4'd13) ^ gm(a2, 4'd9)
					^ gm(a3, 4'd14);
			end
		end
		return r;
	endfunction

	// out-of-range byte counts mean a full block
	assign nb_in = (last_bytes == 5'd0 || last_bytes > 5'(acts_pkg::BLOCK_BYTES)) ?
		5'(acts_pkg::BLOCK_BYTES) : last_bytes;

	assign blk_in = {block_high, block_low};

	always_comb begin
		for (int i = 0; i < acts_pkg::BLOCK_BYTES; i++) begin
			padded[127 - 8 * i -: 8] = (!last_block || 5'(i) < nb_in) ?
				blk_in[127 - 8 * i -: 8] : 8'h00;
			steal[127 - 8 * i -: 8] = (5'(i) < nb_q) ? blk_q[127 - 8 * i -: 8] :
				st_q[127 - 8 * i -: 8];
		end
	end

	assign nr = ks_q ? acts_pkg::NR_256 : acts_pkg::NR_128;
	assign k  = cnt_q + 4'd1;

	always_comb begin
		if (cmd.aes_load) begin
			ridx = dec_q ? nr : 4'd0;
		end else begin
			ridx = dec_q ? nr - k : k;
		end
	end

	acts_keyexp u_keyexp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.ks_start),
		.key256 (ks_q),
		.key    ({key_q[0], key_q[1], key_q[2], key_q[3]}),
		.ridx   (ridx),
		.rk     (rk),
		.busy   (ks_busy)
	);

	always_comb begin
		unique case (cmd.src)
			acts_pkg::SRC_BLK:        src_val = blk_q;
			acts_pkg::SRC_HELD:       src_val = held_q;
			acts_pkg::SRC_HELD_CHAIN: src_val = held_q ^ chain_q;
			acts_pkg::SRC_X_BLK:      src_val = st_q ^ blk_q;
			acts_pkg::SRC_STEAL:      src_val = steal;
			default:                  src_val = blk_q;
		endcase
	end

	assign round_out = dec_q ? dec_round(st_q, rk, k == nr) : enc_round(st_q, rk, k == nr);

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		sts.last      = last_q;
		sts.have_held = have_q;
		sts.dec       = dec_q;
		sts.ks_busy   = ks_busy;
		sts.aes_busy  = busy_q;
		sts.out_free  = out_free;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
			ks_cfg_q  <= 1'b0;
			dir_cfg_q <= 1'b0;
			iv_cfg_q  <= '0;
		end else if (cfg_wr) begin
			unique case (acts_pkg::cfg_idx_t'(cfg_index))
				acts_pkg::CFG_KEY_WORD_0: key_q[0] <= cfg_data;
				acts_pkg::CFG_KEY_WORD_1: key_q[1] <= cfg_data;
				acts_pkg::CFG_KEY_WORD_2: key_q[2] <= cfg_data;
				acts_pkg::CFG_KEY_WORD_3: key_q[3] <= cfg_data;
				acts_pkg::CFG_KEY_SIZE:   ks_cfg_q <= cfg_data[0];
				acts_pkg::CFG_DIRECTION:  dir_cfg_q <= cfg_data[0];
				acts_pkg::CFG_IV_HIGH:    iv_cfg_q[127:64] <= cfg_data;
				acts_pkg::CFG_IV_LOW:     iv_cfg_q[63:0] <= cfg_data;
				default:                  ks_cfg_q <= ks_cfg_q;
			endcase
		end
	end

	// item capture, chaining state and round unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			busy_q <= 1'b0;
			cnt_q  <= '0;
			last_q <= 1'b0;
			dec_q  <= 1'b0;
			ks_q   <= 1'b0;
		end else begin
			if (cmd.cap) begin
				raw_q  <= {block_high, block_low};
				blk_q  <= padded;
				nb_q   <= last_block ? nb_in : 5'(acts_pkg::BLOCK_BYTES);
				last_q <= last_block;
				dec_q  <= dir_cfg_q;
				ks_q   <= ks_cfg_q;
				ivc_q  <= iv_cfg_q;
			end
			if (cmd.store_first) begin
				chain_q <= ivc_q;
				held_q  <= raw_q;
				have_q  <= 1'b1;
			end
			if (cmd.save_x) begin
				x_q <= dec_q ? st_q ^ blk_q : st_q;
			end
			if (cmd.aes_load) begin
				st_q   <= src_val ^ rk;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				st_q  <= round_out;
				cnt_q <= k;
				if (k == nr) begin
					busy_q <= 1'b0;
				end
			end
			if (cmd.out_wr && cmd.out_kind == acts_pkg::OUT_MID) begin
				chain_q <= dec_q ? held_q : st_q;
				held_q  <= raw_q;
			end
			if (cmd.out_wr && cmd.out_kind == acts_pkg::OUT_FINAL) begin
				have_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_wr) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_wr) begin
			unique case (cmd.out_kind)
				acts_pkg::OUT_SINGLE: begin
					out_data  <= st_q;
					out_bytes <= nb_q;
					out_eom   <= 1'b1;
					out_niv   <= ivc_q;
				end
				acts_pkg::OUT_MID, acts_pkg::OUT_Y: begin
					out_data  <= dec_q ? st_q ^ chain_q : st_q;
					out_bytes <= 5'(acts_pkg::BLOCK_BYTES);
					out_eom   <= 1'b0;
					out_niv   <= '0;
				end
				acts_pkg::OUT_FINAL: begin
					out_data  <= x_q;
					out_bytes <= nb_q;
					out_eom   <= 1'b1;
					out_niv   <= dec_q ? held_q : st_q;
				end
				default: begin
					out_data <= st_q;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/acts_ctrl.sv =====
// ----------------------------------------------------------------------------
// acts_ctrl
// Sequencer: capture, key schedule, one or two AES passes, result transfers
// ----------------------------------------------------------------------------
`default_nettype none

module acts_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire acts_pkg::sts_t sts,
	output acts_pkg::cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_EXPAND,
		ST_AES1,
		ST_FIN1,
		ST_AES2,
		ST_FIN2,
		ST_FIN3
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.src      = acts_pkg::SRC_BLK;
		cmd.out_kind = acts_pkg::OUT_SINGLE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!sts.last && !sts.have_held) begin
					cmd.store_first = 1'b1;
					state_d         = ST_IDLE;
				end else begin
					cmd.ks_start = 1'b1;
					state_d      = ST_EXPAND;
				end
			end
			ST_EXPAND: begin
				if (!sts.ks_busy) begin
					cmd.aes_load = 1'b1;
					if (!sts.have_held) begin
						cmd.src = acts_pkg::SRC_BLK;
					end else if (sts.dec) begin
						cmd.src = acts_pkg::SRC_HELD;
					end else begin
						cmd.src = acts_pkg::SRC_HELD_CHAIN;
					end
					state_d = ST_AES1;
				end
			end
			ST_AES1: begin
				if (!sts.aes_busy) begin
					state_d = ST_FIN1;
				end
			end
			ST_FIN1: begin
				// stealing pair: second pass before any transfer
				if (sts.last && sts.have_held) begin
					cmd.save_x   = 1'b1;
					cmd.aes_load = 1'b1;
					cmd.src      = sts.dec ? acts_pkg::SRC_STEAL : acts_pkg::SRC_X_BLK;
					state_d      = ST_AES2;
				end else if (sts.out_free) begin
					cmd.out_wr   = 1'b1;
					cmd.out_kind = sts.have_held ? acts_pkg::OUT_MID : acts_pkg::OUT_SINGLE;
					state_d      = ST_IDLE;
				end
			end
			ST_AES2: begin
				if (!sts.aes_busy) begin
					state_d = ST_FIN2;
				end
			end
			ST_FIN2: begin
				if (sts.out_free) begin
					cmd.out_wr   = 1'b1;
					cmd.out_kind = acts_pkg::OUT_Y;
					state_d      = ST_FIN3;
				end
			end
			ST_FIN3: begin
				if (sts.out_free) begin
					cmd.out_wr   = 1'b1;
					cmd.out_kind = acts_pkg::OUT_FINAL;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/aes_cbc_ciphertext_stealing.sv =====
// ----------------------------------------------------------------------------
// aes_cbc_ciphertext_stealing
// AES-128/256 CBC with ciphertext stealing, one block at a time
// ----------------------------------------------------------------------------
// Each non-final block is held back until the next one arrives. For every
// block that does more than fill the hold register, the key schedule is
// rebuilt, one round key per cycle, then the single round unit loads its
// input and runs one AES round per cycle. A final block after a held one
// runs two AES passes back to back and produces two transfers, the swapped
// pair. Results sit in an output register; the next block is taken while a
// result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_cbc_ciphertext_stealing (
	input  wire logic clk,
	input  wire logic arst_n,
	acts_blk_if.sink  blk,
	acts_res_if.source res,
	acts_cfg_if.sink  cfg
);

	acts_pkg::cmd_t cmd;
	acts_pkg::sts_t sts;
	logic [127:0]   out_data, out_niv;

	assign cfg.ready = 1'b1;

	acts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (blk.valid),
		.in_ready (blk.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	acts_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.block_high (blk.block_high),
		.block_low  (blk.block_low),
		.last_block (blk.last_block),
		.last_bytes (blk.last_bytes),
		.cfg_wr     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.out_valid  (res.valid),
		.out_ready  (res.ready),
		.out_data   (out_data),
		.out_bytes  (res.out_bytes),
		.out_eom    (res.end_of_message),
		.out_niv    (out_niv)
	);

	assign res.out_high     = out_data[127:64];
	assign res.out_low      = out_data[63:0];
	assign res.next_iv_high = out_niv[127:64];
	assign res.next_iv_low  = out_niv[63:0];

	// a new block never arrives while the key schedule or round unit runs
	assert property (@(posedge clk) disable iff (!arst_n)
		(blk.valid && blk.ready) |-> (!sts.ks_busy && !sts.aes_busy))
		else $error("block taken while busy");

	// only the final transfer carries a chaining value
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.end_of_message) |-> (out_niv == '0))
		else $error("chaining value on non-final transfer");

	// byte count always within one block
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.out_bytes != 5'd0 && res.out_bytes <= 5'd16))
		else $error("bad byte count");

endmodule

`default_nettype wire
